@@ rtl/core/cfs_pkg.sv @@
// Package for the clock frequency sanity checker.
// Holds the item codes, alarm codes, FSM state type and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfs_pkg;

    // Item kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FREQ   = 2'd1;
    localparam logic [1:0] KIND_STEP   = 2'd2;

    // Alarm codes
    localparam logic [1:0] ALARM_SANE = 2'd0;
    localparam logic [1:0] ALARM_FAST = 2'd1;
    localparam logic [1:0] ALARM_SLOW = 2'd2;

    // Fixed limits and scale factors
    localparam logic [63:0] MIN_INTERVAL_NS = 64'd100000000;
    localparam logic signed [30:0] MAX_FREQ_PPB = 31'sd900000000;
    localparam logic signed [30:0] FREQ_SAT     = 31'sd999999999;
    localparam logic [63:0] NS_PER_SEC      = 64'd1000000000;
    localparam logic [63:0] NS_SQ           = 64'd1000000000000000000;
    localparam logic [29:0] LIMIT_RESET     = 30'd200000000;

    // Configuration register index
    localparam logic REG_PPB_LIMIT = 1'b0;

    // Widths
    localparam int unsigned MUL_W  = 64;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned CNT_W  = $clog2(MUL_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DONE
    } cfs_state_t;

endpackage
`default_nettype wire

@@ rtl/core/cfs_if.sv @@
// Item channel interfaces for the clock frequency sanity checker.
// Input channel carries the sample/set/step fields, output channel the alarm.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface cfs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [63:0]        sync_time;
    logic [63:0]        mono_time;
    logic signed [30:0] freq_ppb;
    logic signed [63:0] step_ns;

    modport source (output valid, kind, sync_time, mono_time, freq_ppb, step_ns,
                    input ready);
    modport sink (input valid, kind, sync_time, mono_time, freq_ppb, step_ns,
                  output ready);
endinterface

interface cfs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] alarm;

    modport source (output valid, alarm, input ready);
    modport sink (input valid, alarm, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cfs_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Produces a full 128-bit product of two 64-bit unsigned operands; uses cfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfs_mul
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [cfs_pkg::MUL_W-1:0]     a,
    input  wire logic [cfs_pkg::MUL_W-1:0]     b,
    output logic                               done,
    output logic [cfs_pkg::PROD_W-1:0]         prod
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [cfs_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [cfs_pkg::MUL_W-1:0]     a_reg, a_next;
    logic [cfs_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [cfs_pkg::MUL_W:0]       sum;

    // Add multiplicand into the upper half when the low bit is set, then shift
    always_comb
    begin
        sum = {1'b0, prod_reg[cfs_pkg::PROD_W-1:cfs_pkg::MUL_W]}
            + (prod_reg[0] ? {1'b0, a_reg} : '0);
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        prod_next = prod_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            prod_next = {{cfs_pkg::MUL_W{1'b0}}, b};
        end
        else if (run_reg)
        begin
            prod_next = {sum, prod_reg[cfs_pkg::MUL_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == {cfs_pkg::CNT_W{1'b1}})
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operand and partial product
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ rtl/core/cfs_apb.sv @@
// APB-style configuration port holding the frequency limit register.
// Uses cfs_pkg for the register index and reset value.
`timescale 1ns / 1ps
`default_nettype none
module cfs_apb
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [29:0]      ppb_limit
);

    logic [29:0] limit_reg, limit_next;
    logic        wr_en;

    // Decode a completed write to the limit register
    always_comb
    begin
        wr_en      = psel && penable && pwrite && (paddr[2] == cfs_pkg::REG_PPB_LIMIT);
        limit_next = wr_en ? pwdata[29:0] : limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= cfs_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // Read back the register; other addresses read zero
    always_comb
    begin
        prdata = (paddr[2] == cfs_pkg::REG_PPB_LIMIT) ? {2'b00, limit_reg} : '0;
    end

    assign pready    = 1'b1;
    assign ppb_limit = limit_reg;

endmodule
`default_nettype wire

@@ rtl/core/clock_frequency_sanity_check.sv @@
// Top level of the clock frequency sanity checker.
// Depends on cfs_pkg, cfs_if, cfs_mul and cfs_apb.
//
// Each input item gives exactly one alarm item. Frequency-set, step, unused and
// ignored sample items go from S_IDLE to S_DONE; from there their result is
// loaded into the output register once that register is free.
// A sample that is checked runs two passes of 64-bit bit-serial multipliers
// (one multiplier bit per cycle): first dmag*1e18 and both limit factors in
// parallel, then both factors times the monotonic interval; its result also goes
// through S_DONE to the output register. One item is in work at a time; the next
// item is accepted while a finished alarm still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module clock_frequency_sanity_check
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfs_in_if.sink      din,
    cfs_out_if.source   dout,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfs_pkg::cfs_state_t state_reg, state_next;

    logic [29:0]          ppb_limit;
    logic                 freq_known_reg, freq_known_next;
    logic signed [30:0]   cur_freq_reg, cur_freq_next;
    logic signed [30:0]   max_reg, max_next;
    logic signed [30:0]   min_reg, min_next;
    logic [63:0]          last_sync_reg, last_sync_next;
    logic [63:0]          last_mono_reg, last_mono_next;
    logic [63:0]          md_reg, md_next;
    logic                 dneg_reg, dneg_next;
    logic                 cneg_reg, cneg_next;
    logic [1:0]           alarm_reg, alarm_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_alarm_reg, out_alarm_next;

    logic                 accept;
    logic [63:0]          d, dmag, md, cmag, fa, fb, ca, cb;
    logic                 dneg, smp_take, smp_check;
    logic signed [30:0]   fsat;
    logic                 start1, start2, out_load;
    logic                 lhs_done, f1_done, f2_done;
    logic [127:0]         lhs_prod, f1_prod, f2_prod;
    logic [63:0]          f1_a, f1_b, f2_a, f2_b;
    logic                 gt1, lt2;
    logic [1:0]           alarm_calc;

    cfs_apb u_apb
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .ppb_limit  (ppb_limit)
    );

    // Screen the incoming item against the stored state
    always_comb
    begin
        accept    = din.valid && din.ready;
        d         = din.sync_time - last_sync_reg;
        dneg      = d[63];
        dmag      = dneg ? (64'd0 - d) : d;
        md        = din.mono_time - last_mono_reg;
        smp_take  = freq_known_reg && !(!dneg && (d < cfs_pkg::MIN_INTERVAL_NS))
                    && !(md[63] || (md < cfs_pkg::MIN_INTERVAL_NS));
        smp_check = smp_take && (last_sync_reg != 64'd0)
                    && (max_reg <= cfs_pkg::MAX_FREQ_PPB);
        fa        = cfs_pkg::NS_PER_SEC + {34'd0, ppb_limit};
        fb        = cfs_pkg::NS_PER_SEC + {{33{max_reg[30]}}, max_reg};
        cmag      = ({34'd0, ppb_limit} > cfs_pkg::NS_PER_SEC)
                    ? ({34'd0, ppb_limit} - cfs_pkg::NS_PER_SEC)
                    : (cfs_pkg::NS_PER_SEC - {34'd0, ppb_limit});
        cb        = cfs_pkg::NS_PER_SEC + {{33{min_reg[30]}}, min_reg};
        ca        = cmag;
        if (din.freq_ppb > cfs_pkg::FREQ_SAT)
        begin
            fsat = cfs_pkg::FREQ_SAT;
        end
        else if (din.freq_ppb < -cfs_pkg::FREQ_SAT)
        begin
            fsat = -cfs_pkg::FREQ_SAT;
        end
        else
        begin
            fsat = din.freq_ppb;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ((din.kind == cfs_pkg::KIND_SAMPLE) && smp_check)
                                 ? cfs_pkg::S_MUL1 : cfs_pkg::S_DONE;
                end
            end
            cfs_pkg::S_MUL1:
            begin
                if (f1_done)
                begin
                    state_next = cfs_pkg::S_MUL2;
                end
            end
            cfs_pkg::S_MUL2:
            begin
                if (f1_done)
                begin
                    state_next = cfs_pkg::S_DONE;
                end
            end
            cfs_pkg::S_DONE:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    state_next = cfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cfs_pkg::S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        din.ready = (state_reg == cfs_pkg::S_IDLE);
        start1    = (state_reg == cfs_pkg::S_IDLE) && din.valid
                    && (din.kind == cfs_pkg::KIND_SAMPLE) && smp_check;
        start2    = (state_reg == cfs_pkg::S_MUL1) && f1_done;
        out_load  = (state_reg == cfs_pkg::S_DONE) && (!out_valid_reg || dout.ready);
    end

    // Select multiplier operands for the first and second pass
    always_comb
    begin
        if (state_reg == cfs_pkg::S_MUL1)
        begin
            f1_a = f1_prod[63:0];
            f1_b = md_reg;
            f2_a = f2_prod[63:0];
            f2_b = md_reg;
        end
        else
        begin
            f1_a = fa;
            f1_b = fb;
            f2_a = ca;
            f2_b = cb;
        end
    end

    cfs_mul u_mul_lhs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start1),
        .a     (dmag),
        .b     (cfs_pkg::NS_SQ),
        .done  (lhs_done),
        .prod  (lhs_prod)
    );

    cfs_mul u_mul_fast
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start1 || start2),
        .a     (f1_a),
        .b     (f1_b),
        .done  (f1_done),
        .prod  (f1_prod)
    );

    cfs_mul u_mul_slow
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start1 || start2),
        .a     (f2_a),
        .b     (f2_b),
        .done  (f2_done),
        .prod  (f2_prod)
    );

    // Compare scaled sync interval against both bounds
    always_comb
    begin
        gt1 = lhs_prod > f1_prod;
        if (dneg_reg != cneg_reg)
        begin
            lt2 = dneg_reg;
        end
        else if (dneg_reg)
        begin
            lt2 = lhs_prod > f2_prod;
        end
        else
        begin
            lt2 = lhs_prod < f2_prod;
        end
        if (!dneg_reg && gt1)
        begin
            alarm_calc = cfs_pkg::ALARM_FAST;
        end
        else if (lt2)
        begin
            alarm_calc = cfs_pkg::ALARM_SLOW;
        end
        else
        begin
            alarm_calc = cfs_pkg::ALARM_SANE;
        end
    end

    // Update clock state and result
    always_comb
    begin
        freq_known_next = freq_known_reg;
        cur_freq_next   = cur_freq_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        last_sync_next  = last_sync_reg;
        last_mono_next  = last_mono_reg;
        md_next         = md_reg;
        dneg_next       = dneg_reg;
        cneg_next       = cneg_reg;
        alarm_next      = alarm_reg;
        out_valid_next  = out_valid_reg;
        out_alarm_next  = out_alarm_reg;

        if (accept)
        begin
            alarm_next = cfs_pkg::ALARM_SANE;
            md_next    = md;
            dneg_next  = dneg;
            cneg_next  = {34'd0, ppb_limit} > cfs_pkg::NS_PER_SEC;
            case (din.kind)
                cfs_pkg::KIND_SAMPLE:
                begin
                    if (smp_take)
                    begin
                        last_mono_next = din.mono_time;
                        last_sync_next = din.sync_time;
                        max_next       = cur_freq_reg;
                        min_next       = cur_freq_reg;
                    end
                end
                cfs_pkg::KIND_FREQ:
                begin
                    if (max_reg < fsat)
                    begin
                        max_next = fsat;
                    end
                    if (min_reg > fsat)
                    begin
                        min_next = fsat;
                    end
                    cur_freq_next   = fsat;
                    freq_known_next = 1'b1;
                end
                cfs_pkg::KIND_STEP:
                begin
                    if (last_sync_reg != 64'd0)
                    begin
                        last_sync_next = last_sync_reg + din.step_ns;
                    end
                end
                default:
                begin
                    last_sync_next = last_sync_reg;
                end
            endcase
        end

        if ((state_reg == cfs_pkg::S_MUL2) && f2_done && lhs_done == 1'b0)
        begin
            alarm_next = alarm_calc;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_alarm_next = alarm_reg;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cfs_pkg::S_IDLE;
            freq_known_reg <= 1'b0;
            cur_freq_reg   <= '0;
            max_reg        <= -cfs_pkg::MAX_FREQ_PPB;
            min_reg        <= cfs_pkg::MAX_FREQ_PPB;
            last_sync_reg  <= '0;
            last_mono_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            freq_known_reg <= freq_known_next;
            cur_freq_reg   <= cur_freq_next;
            max_reg        <= max_next;
            min_reg        <= min_next;
            last_sync_reg  <= last_sync_next;
            last_mono_reg  <= last_mono_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold per-item working values
    always_ff @(posedge clk)
    begin
        md_reg        <= md_next;
        dneg_reg      <= dneg_next;
        cneg_reg      <= cneg_next;
        alarm_reg     <= alarm_next;
        out_alarm_reg <= out_alarm_next;
    end

    assign dout.valid = out_valid_reg;
    assign dout.alarm = out_alarm_reg;

endmodule
`default_nettype wire

@@ rtl/core/cfs_checker.sv @@
// Port-level checker for the clock frequency sanity checker, with its bind.
// Depends on cfs_pkg and the top level clock_frequency_sanity_check.
`timescale 1ns / 1ps
`default_nettype none
module cfs_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] in_kind,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_alarm
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_alarm))
        else $error("result dropped or changed while stalled");

    // Alarm code is never the unused value
    a_alarm_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_alarm == cfs_pkg::ALARM_SANE
                       || out_alarm == cfs_pkg::ALARM_FAST
                       || out_alarm == cfs_pkg::ALARM_SLOW))
        else $error("bad alarm code");

    // Non-sample item taken while output is free gives a sane result
    a_quick_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind != cfs_pkg::KIND_SAMPLE) && !out_valid
        |-> ##2 (out_valid && out_alarm == cfs_pkg::ALARM_SANE))
        else $error("non-sample item result missing or nonzero");

    // No new item taken in the cycle right after one was taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while first in work");

endmodule

bind clock_frequency_sanity_check cfs_checker u_cfs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_kind   (din.kind),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_alarm (dout.alarm)
);
`default_nettype wire
